// ----- design/stereo_feedback_delay_assert.svh -----
// Assertion macros shared by the delay block; clock aclk, reset aresetn.
`ifndef STEREO_FEEDBACK_DELAY_ASSERT_SVH
`define STEREO_FEEDBACK_DELAY_ASSERT_SVH

// Check a condition at every clock edge outside reset
`define SFD_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) else $error(msg);

// Check a consequence in the cycle after a trigger
`define SFD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/sfd_pkg.sv -----
`default_nettype none
package sfd_pkg;

    // Delay memory geometry (power of two, so position math wraps by truncation)
    localparam int BUF_DEPTH = 65536;
    localparam int AW        = $clog2(BUF_DEPTH);

    localparam int SAMPLE_W  = 16;
    localparam int CFG_IDX_W = 4;

    // Output queue depth and the width of its pointers and occupancy
    localparam int FIFO_DEPTH = 3;
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DELAY_LENGTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK_GAIN = CFG_IDX_W'(1);

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    // Write-back stage control, shared by both lanes
    typedef struct packed {
        logic          valid;   // an item is in the write-back stage
        logic [AW-1:0] wr_addr; // position the result goes to
        logic          hit;     // read entry has been written since reset
        logic          fwd;     // read entry is the one written by the previous item
    } sfd_wb_t;

endpackage
`default_nettype wire

// ----- design/sfd_lane.sv -----
`default_nettype none
module sfd_lane import sfd_pkg::*; (
    input  wire logic                aclk,
    input  wire logic                issue,
    input  wire logic [AW-1:0]       rd_addr,
    input  wire sample_t             sample_in,
    input  wire sfd_wb_t             wb,
    input  wire logic [SAMPLE_W-1:0] gain,
    output sample_t                  result
);

    sample_t mem [BUF_DEPTH];
    sample_t rd_data_reg;
    sample_t sample_reg;
    sample_t last_wr_reg;

    sample_t                   stored;
    logic signed [32:0]        prod;
    logic signed [33:0]        acc;
    logic signed [17:0]        quot;

    // Read the feedback tap and hold the sample on issue; write back the result
    always_ff @(posedge aclk) begin
        if (issue) begin
            rd_data_reg <= mem[rd_addr];
            sample_reg  <= sample_in;
        end
        if (wb.valid) begin
            mem[wb.wr_addr] <= result;
            last_wr_reg     <= result;
        end
    end

    // Pick the tap: forwarded previous result, stored entry, or cleared entry
    always_comb begin
        if (wb.fwd) begin
            stored = last_wr_reg;
        end else if (wb.hit) begin
            stored = rd_data_reg;
        end else begin
            stored = '0;
        end
    end

    // Scale, add, round and saturate
    always_comb begin
        prod = stored * $signed({1'b0, gain});
        acc  = $signed({{2{sample_reg[SAMPLE_W-1]}}, sample_reg, 16'h0000})
             + $signed({prod[32], prod})
             + 34'sd32768;
        quot = acc[33:16];
        if (quot > 18'sd32767) begin
            result = 16'sh7FFF;
        end else if (quot < -18'sd32768) begin
            result = -16'sh8000;
        end else begin
            result = quot[15:0];
        end
    end

endmodule
`default_nettype wire

// ----- design/sfd_merge.sv -----
`default_nettype none
`include "stereo_feedback_delay_assert.svh"
module sfd_merge import sfd_pkg::*; (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push,
    input  wire sample_t           left_res,
    input  wire sample_t           right_res,
    output logic [FIFO_CW-1:0]     level,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [2*SAMPLE_W-1:0]  m_tdata   // left_out, right_out
);

    logic [2*SAMPLE_W-1:0] fifo_mem [FIFO_DEPTH];
    logic [FIFO_CW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_CW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CW-1:0] count_reg, count_next;
    logic       pop;
    logic       full;

    assign pop      = m_tvalid && m_tready;
    assign m_tvalid = (count_reg != '0);
    assign m_tdata  = fifo_mem[rd_ptr_reg];
    assign level    = count_reg;
    assign full     = (count_reg == FIFO_CW'(FIFO_DEPTH));

    // Advance pointers and occupancy
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == FIFO_CW'(FIFO_DEPTH - 1)) ? '0
                                                                   : wr_ptr_reg + FIFO_CW'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == FIFO_CW'(FIFO_DEPTH - 1)) ? '0
                                                                   : rd_ptr_reg + FIFO_CW'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + FIFO_CW'(1);
        end else if (pop && !push) begin
            count_next = count_reg - FIFO_CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Pack both lanes into one item
    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_mem[wr_ptr_reg] <= {right_res, left_res};
        end
    end

    `SFD_ASSERT_ALWAYS(a_no_overflow, !(push && !pop && full), "merge fifo overflow")
    `SFD_ASSERT_NEXT(a_count_up, push && !pop, count_reg == $past(count_reg) + FIFO_CW'(1), "count did not rise")
    `SFD_ASSERT_NEXT(a_count_down, pop && !push, count_reg == $past(count_reg) - FIFO_CW'(1), "count did not fall")

endmodule
`default_nettype wire

// ----- design/stereo_feedback_delay.sv -----
// Path: an accepted item is registered into the write-back stage, whose result is pushed into the output queue.
// Throughput: one item per cycle while the output queue has room; the tap read, multiply-add
// and write-back of the previous item are closed through a forwarding register, and a
// three-entry output queue keeps the input ready while one result waits.
// Reset: aresetn (synchronous, active low) clears position, fill count, queue and stage control;
// delay memories need no clearing pass, entries not yet written since reset read as zero.
`default_nettype none
module stereo_feedback_delay import sfd_pkg::*; (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [2*SAMPLE_W-1:0] s_tdata,   // left_in, right_in
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [2*SAMPLE_W-1:0]      m_tdata,   // left_out, right_out
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [SAMPLE_W-1:0]   cfg_data
);

    localparam logic [AW:0] FILL_FULL = (AW+1)'(BUF_DEPTH);

    logic [SAMPLE_W-1:0] delay_reg;
    logic [SAMPLE_W-1:0] gain_reg;
    logic [AW-1:0]       pos_reg;
    logic [AW:0]         fill_reg;
    sfd_wb_t             wb_reg, wb_next;

    logic               accept;
    logic [AW-1:0]      rd_addr;
    logic [FIFO_CW-1:0] level;
    sample_t            left_res;
    sample_t            right_res;

    assign cfg_ready = 1'b1;
    assign s_tready  = ({1'b0, level} + {{FIFO_CW{1'b0}}, wb_reg.valid})
                       <= (FIFO_CW+1)'(FIFO_DEPTH - 1);
    assign accept    = s_tvalid && s_tready;
    assign rd_addr   = pos_reg - AW'(delay_reg);

    // Tag the read with its fill and forwarding status
    always_comb begin
        wb_next.valid   = accept;
        wb_next.wr_addr = pos_reg;
        wb_next.hit     = ({1'b0, rd_addr} < fill_reg);
        wb_next.fwd     = wb_reg.valid && (wb_reg.wr_addr == rd_addr);
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delay_reg <= 16'd22500;
            gain_reg  <= 16'd32768;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_DELAY_LENGTH:  delay_reg <= cfg_data;
                REG_FEEDBACK_GAIN: gain_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // Advance position, stage control and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg  <= '0;
            fill_reg <= '0;
            wb_reg   <= '0;
        end else begin
            wb_reg <= wb_next;
            if (accept) begin
                pos_reg <= pos_reg + AW'(1);
            end
            if (wb_reg.valid && fill_reg != FILL_FULL) begin
                fill_reg <= fill_reg + (AW+1)'(1);
            end
        end
    end

    sfd_lane u_lane_left (
        .aclk      (aclk),
        .issue     (accept),
        .rd_addr   (rd_addr),
        .sample_in (s_tdata[SAMPLE_W-1:0]),
        .wb        (wb_reg),
        .gain      (gain_reg),
        .result    (left_res)
    );

    sfd_lane u_lane_right (
        .aclk      (aclk),
        .issue     (accept),
        .rd_addr   (rd_addr),
        .sample_in (s_tdata[2*SAMPLE_W-1:SAMPLE_W]),
        .wb        (wb_reg),
        .gain      (gain_reg),
        .result    (right_res)
    );

    sfd_merge u_merge (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (wb_reg.valid),
        .left_res  (left_res),
        .right_res (right_res),
        .level     (level),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule
`default_nettype wire

// ----- sim/testbench.sv -----
`default_nettype none
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import sfd_pkg::*;

    // Register values after reset
    localparam logic [SAMPLE_W-1:0] DELAY_AT_RESET = 16'd22500;
    localparam logic [SAMPLE_W-1:0] GAIN_AT_RESET  = 16'd32768;
    // Indexes that decode to no register
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = '1;

    localparam int HOLD_CYCLES      = 300;
    localparam int SETTLE_CYCLES    = 6;
    localparam int RANDOM_PHASES    = 8;
    localparam int FRAMES_PER_PHASE = 250;
    localparam int HOLD_PHASE       = 6;
    localparam int TIMEOUT_NS       = 3_000_000;

    // One stereo frame, left in the low half as on the bus
    typedef struct packed {
        sample_t right;
        sample_t left;
    } stereo_t;

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [2*SAMPLE_W-1:0] s_tdata   = '0;    // left_in, right_in
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [2*SAMPLE_W-1:0] m_tdata;           // left_out, right_out
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [SAMPLE_W-1:0]   cfg_data  = '0;

    stereo_t frames_to_send [$];
    stereo_t expected_mix [$];
    int      mix_errors    = 0;
    int      send_idle_pct = 0;
    int      recv_idle_pct = 0;
    logic    in_taken      = 1'b0;
    logic    hold_req      = 1'b0;
    int      hold_count    = 0;
    wire     hold_active   = hold_req && (hold_count < HOLD_CYCLES);

    // Predictor state: echo history, write position and register copies
    bit signed [SAMPLE_W-1:0] left_hist  [BUF_DEPTH];
    bit signed [SAMPLE_W-1:0] right_hist [BUF_DEPTH];
    int                       wr_pos;
    logic [SAMPLE_W-1:0]      tap_delay;
    logic [SAMPLE_W-1:0]      fb_gain;

    stereo_feedback_delay dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("[FAIL] regression broken");
        $finish;
    end

    // Dry sample plus the echo scaled by the Q0.16 gain, rounded half up, saturated
    function automatic sample_t feedback_mix(sample_t dry, sample_t echo,
                                             logic [SAMPLE_W-1:0] gain);
        longint acc;
        acc = longint'(dry) * 65536 + longint'(echo) * longint'(gain) + 32768;
        acc = acc >>> 16;
        if (acc > 32767)
            acc = 32767;
        else if (acc < -32768)
            acc = -32768;
        return sample_t'(acc);
    endfunction

    // Track registers, predict each accepted item, check each result
    always @(posedge aclk) begin
        stereo_t frame;
        stereo_t mixed;
        stereo_t want;
        stereo_t got;
        int      tap;
        if (!aresetn) begin
            in_taken  <= 1'b0;
            wr_pos     = 0;
            tap_delay  = DELAY_AT_RESET;
            fb_gain    = GAIN_AT_RESET;
        end else begin
            in_taken <= s_tvalid && s_tready;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_DELAY_LENGTH:  tap_delay = cfg_data;
                    REG_FEEDBACK_GAIN: fb_gain   = cfg_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                frame = stereo_t'(s_tdata);
                tap   = (wr_pos + BUF_DEPTH - (int'(tap_delay) % BUF_DEPTH)) % BUF_DEPTH;
                mixed.left  = feedback_mix(frame.left, left_hist[tap], fb_gain);
                mixed.right = feedback_mix(frame.right, right_hist[tap], fb_gain);
                left_hist[wr_pos]  = mixed.left;
                right_hist[wr_pos] = mixed.right;
                expected_mix.push_back(mixed);
                wr_pos = (wr_pos + 1) % BUF_DEPTH;
            end
            if (m_tvalid && m_tready) begin
                got = stereo_t'(m_tdata);
                if (expected_mix.size() == 0) begin
                    $error("result with nothing expected: left_out %0d right_out %0d",
                           got.left, got.right);
                    mix_errors++;
                end else begin
                    want = expected_mix.pop_front();
                    if (got.left !== want.left) begin
                        $error("left_out expected %0d actual %0d", want.left, got.left);
                        mix_errors++;
                    end
                    if (got.right !== want.right) begin
                        $error("right_out expected %0d actual %0d", want.right, got.right);
                        mix_errors++;
                    end
                end
            end
        end
    end

    // Offer the next frame once the current one is taken; idle at random
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || in_taken) begin
            if (frames_to_send.size() != 0 &&
                (hold_active || $urandom_range(99) >= send_idle_pct)) begin
                s_tvalid <= 1'b1;
                s_tdata  <= frames_to_send.pop_front();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Accept results at random; hold off for a long stretch once on request
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_active) begin
            m_tready   <= 1'b0;
            hold_count <= hold_count + 1;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [SAMPLE_W-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic push_frame(input sample_t left, input sample_t right);
        stereo_t frame;
        frame.left  = left;
        frame.right = right;
        frames_to_send.push_back(frame);
    endtask

    // Block the caller until every queued item is out and every result is back
    task automatic drain();
        while (frames_to_send.size() != 0 || s_tvalid || expected_mix.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_idling(input int mode);
        case (mode)
            0: begin send_idle_pct = 21; recv_idle_pct = 49; end
            1: begin send_idle_pct = 49; recv_idle_pct = 21; end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
        endcase
    endtask

    initial begin
        logic [SAMPLE_W-1:0] delay_plan [RANDOM_PHASES];
        logic [SAMPLE_W-1:0] gain_plan  [RANDOM_PHASES];
        sample_t             corner     [4];

        corner = '{16'sh7fff, 16'sh8000, 16'sh0000, 16'shffff};
        delay_plan = '{16'd1, 16'd2, 16'd0, 16'd65535,
                       16'($urandom_range(3, 200)), 16'($urandom_range(200, 1500)),
                       16'($urandom_range(1, 64)), 16'($urandom_range(1, 400))};
        gain_plan  = '{16'd65535, 16'd49152, 16'd40000, 16'd65535,
                       16'($urandom), 16'($urandom_range(60000, 65535)),
                       16'd0, 16'd32768};

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        set_idling(0);

        // Extremes at the reset setting; the tap reads cleared entries
        push_frame(16'sh7fff, 16'sh8000);
        push_frame(16'sh8000, 16'sh7fff);
        push_frame(16'sh0000, 16'shffff);
        push_frame(16'sh5555, 16'shaaaa);
        drain();

        // Writes to unused indexes must leave both registers alone
        write_reg(REG_UNUSED_LO, 16'($urandom));
        write_reg(REG_UNUSED_HI, 16'($urandom));
        push_frame(16'sh1234, -16'sh1234);
        drain();

        // Rounding ties: +0.5 goes up, -0.5 goes to zero
        write_reg(REG_DELAY_LENGTH, 16'd1);
        write_reg(REG_FEEDBACK_GAIN, 16'd32768);
        push_frame(16'sh0001, 16'shffff);
        push_frame(16'sh0000, 16'sh0000);
        push_frame(16'shfffd, 16'sh0003);
        push_frame(16'sh0000, 16'sh0000);
        drain();

        // Near-unity gain drives both rails into saturation
        write_reg(REG_FEEDBACK_GAIN, 16'd65535);
        push_frame(16'sh7fff, 16'sh8000);
        push_frame(16'sh7fff, 16'sh8000);
        push_frame(16'sh7fff, 16'sh8000);
        push_frame(16'sh0000, 16'sh0000);
        push_frame(16'sh8000, 16'sh7fff);
        push_frame(16'sh8000, 16'sh7fff);
        drain();

        // Zero gain passes the dry signal through
        write_reg(REG_FEEDBACK_GAIN, 16'd0);
        push_frame(16'sh007b, -16'sh01c8);
        push_frame(16'sh8000, 16'sh7fff);
        drain();

        // Random frames under a sweep of delay and gain settings
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            set_idling(p * 3 / RANDOM_PHASES);
            write_reg(REG_DELAY_LENGTH, delay_plan[p]);
            write_reg(REG_FEEDBACK_GAIN, gain_plan[p]);
            if (p == HOLD_PHASE)
                hold_req = 1'b1;
            for (int n = 0; n < FRAMES_PER_PHASE; n++) begin
                case ($urandom_range(9))
                    0:       push_frame(corner[$urandom_range(3)], corner[$urandom_range(3)]);
                    1, 2, 3: push_frame(sample_t'(int'($urandom_range(2000)) - 1000),
                                        sample_t'(int'($urandom_range(2000)) - 1000));
                    default: push_frame(sample_t'($urandom), sample_t'($urandom));
                endcase
            end
            drain();
        end

        if (mix_errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
`default_nettype wire

// ----- stereo_feedback_delay.f -----
+incdir+design
design/sfd_pkg.sv
design/sfd_lane.sv
design/sfd_merge.sv
design/stereo_feedback_delay.sv
sim/testbench.sv
